FILE: hdl/wqm_pkg.sv
// Shared types and constants for the weighted quadrangle merger.
`timescale 1ns / 1ps
package wqm_pkg;
   localparam int NUM_LANES  = 8;
   localparam int NUM_VERTS  = 4;
   localparam int NUM_ORDERS = 8;
   localparam int STEP_BITS  = 2;

   typedef struct packed {
      logic clear;
      logic mul_en;
      logic add_en;
      logic div_start;
   } lane_ctrl_type;
endpackage

FILE: hdl/weighted_quad_merger.sv
// One item is in work at a time: for a group with members, two rounds of eight parallel
// 2-bit-per-cycle dividers and the eight-way ordering search lie between the input transfer
// and the result in the output register; the first item of a group and an item that is
// refused take a single divider round. A new item is taken once the previous result is
// loaded, even if it still waits. Synchronous active-high reset clears state.
`timescale 1ns / 1ps
module weighted_quad_merger #(
   parameter int COORD_BITS      = 16,
   parameter int SCORE_FRAC_BITS = 15,
   parameter int MAX_MERGES      = 1024
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // x0, y0, x1, y1, x2, y2, x3, y3, weight, zero fill.
   input  logic [((8*COORD_BITS+SCORE_FRAC_BITS+1+7)/8)*8-1:0] req_tdata,
   // start_group.
   input  logic req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // avg_x0, avg_y0, avg_x1, avg_y1, avg_x2, avg_y2, avg_x3, avg_y3, total_weight, zero fill.
   output logic [((8*COORD_BITS+SCORE_FRAC_BITS+1+$clog2(MAX_MERGES)+7)/8)*8-1:0] rsp_tdata,
   // overflow.
   output logic rsp_tuser
);
   localparam int C      = COORD_BITS;
   localparam int WF     = SCORE_FRAC_BITS + 1;
   localparam int WS     = WF + $clog2(MAX_MERGES);
   localparam int SUM_W  = C + WF + $clog2(MAX_MERGES);
   localparam int CNT_W  = $clog2(MAX_MERGES + 1);
   localparam int RSP_DW = ((8 * C + WS + 7) / 8) * 8;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_CHECK  = 4'd1;
   localparam logic [3:0] S_DIV1   = 4'd2;
   localparam logic [3:0] S_MATCH  = 4'd3;
   localparam logic [3:0] S_MUL    = 4'd4;
   localparam logic [3:0] S_ADD    = 4'd5;
   localparam logic [3:0] S_DSTART = 4'd6;
   localparam logic [3:0] S_DIV2   = 4'd7;
   localparam logic [3:0] S_OUT    = 4'd8;

   logic [3:0]          state_ff, state_in;
   logic signed [C-1:0] px_ff [wqm_pkg::NUM_VERTS];
   logic signed [C-1:0] py_ff [wqm_pkg::NUM_VERTS];
   logic [WF-1:0]       weight_ff;
   logic [WS-1:0]       wsum_ff, wsum_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                ovf_ff, ovf_in;
   logic [1:0]          ostart_ff, ostart_in;
   logic                orev_ff, orev_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RSP_DW-1:0]   rsp_data_ff, rsp_data_in;
   logic                rsp_user_ff;
   logic                accept;
   logic                full;
   logic                load;
   logic                all_done;
   logic                match_start;
   logic                match_done;
   logic [1:0]          pick_start;
   logic                best_rev;
   logic [WS-1:0]       divisor;
   wqm_pkg::lane_ctrl_type lane_ctrl;
   logic signed [C-1:0] lane_coord [wqm_pkg::NUM_LANES];
   logic signed [C-1:0] lane_avg [wqm_pkg::NUM_LANES];
   logic [wqm_pkg::NUM_LANES-1:0] lane_done;
   logic signed [C-1:0] avg_x [wqm_pkg::NUM_VERTS];
   logic signed [C-1:0] avg_y [wqm_pkg::NUM_VERTS];
   logic [1:0]          src;

   assign accept      = req_tvalid && req_tready;
   assign req_tready  = (state_ff == S_IDLE);
   assign full        = (count_ff >= CNT_W'(MAX_MERGES));
   assign all_done    = &lane_done;
   assign match_start = (state_ff == S_DIV1) && all_done;
   assign load        = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_tready);
   assign divisor     = (wsum_ff == '0) ? WS'(1) : wsum_ff;

   always_comb begin
      lane_ctrl.clear     = accept && req_tuser;
      lane_ctrl.mul_en    = (state_ff == S_MUL);
      lane_ctrl.add_en    = (state_ff == S_ADD);
      lane_ctrl.div_start = (state_ff == S_CHECK && !full && count_ff != '0)
                            || (state_ff == S_DSTART);
   end

   always_comb begin
      for (int k = 0; k < wqm_pkg::NUM_LANES; k++) begin
         src = orev_ff ? (ostart_ff + 2'd3 - 2'(k >> 1)) : (ostart_ff + 2'(k >> 1));
         lane_coord[k] = k[0] ? py_ff[src] : px_ff[src];
      end
      for (int i = 0; i < wqm_pkg::NUM_VERTS; i++) begin
         avg_x[i] = lane_avg[2*i];
         avg_y[i] = lane_avg[2*i+1];
      end
   end

   for (genvar g = 0; g < wqm_pkg::NUM_LANES; g++) begin : g_lane
      wqm_lane #(
         .C     (C),
         .WF    (WF),
         .WS    (WS),
         .SUM_W (SUM_W)
      ) u_lane (
         .clock   (clock),
         .reset   (reset),
         .ctrl    (lane_ctrl),
         .coord   (lane_coord[g]),
         .weight  (weight_ff),
         .divisor (divisor),
         .avg     (lane_avg[g]),
         .done    (lane_done[g])
      );
   end

   wqm_match #(
      .C (C)
   ) u_match (
      .clock      (clock),
      .reset      (reset),
      .start      (match_start),
      .avg_x      (avg_x),
      .avg_y      (avg_y),
      .pt_x       (px_ff),
      .pt_y       (py_ff),
      .pick_start (pick_start),
      .best_rev   (best_rev),
      .done       (match_done)
   );

   always_comb begin
      state_in  = state_ff;
      wsum_in   = wsum_ff;
      count_in  = count_ff;
      ovf_in    = ovf_ff;
      ostart_in = ostart_ff;
      orev_in   = orev_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_CHECK;
               if (req_tuser) begin
                  wsum_in  = '0;
                  count_in = '0;
                  ovf_in   = 1'b0;
               end
            end
         end
         S_CHECK: begin
            ostart_in = 2'd0;
            orev_in   = 1'b0;
            if (full) begin
               ovf_in   = 1'b1;
               state_in = S_DSTART;
            end else if (count_ff != '0) begin
               state_in = S_DIV1;
            end else begin
               state_in = S_MUL;
            end
         end
         S_DIV1: if (all_done) state_in = S_MATCH;
         S_MATCH: begin
            if (match_done) begin
               ostart_in = pick_start;
               orev_in   = best_rev;
               state_in  = S_MUL;
            end
         end
         S_MUL: state_in = S_ADD;
         S_ADD: begin
            wsum_in  = wsum_ff + WS'(weight_ff);
            count_in = count_ff + CNT_W'(1);
            state_in = S_DSTART;
         end
         S_DSTART: state_in = S_DIV2;
         S_DIV2: if (all_done) state_in = S_OUT;
         S_OUT: if (load) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_data_in = '0;
      for (int k = 0; k < wqm_pkg::NUM_LANES; k++) begin
         rsp_data_in[k*C +: C] = lane_avg[k];
      end
      rsp_data_in[8*C +: WS] = wsum_ff;
      rsp_valid_in = load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wsum_ff      <= '0;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         ostart_ff    <= 2'd0;
         orev_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wsum_ff      <= wsum_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         ostart_ff    <= ostart_in;
         orev_ff      <= orev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         for (int v = 0; v < wqm_pkg::NUM_VERTS; v++) begin
            px_ff[v] <= req_tdata[2*v*C +: C];
            py_ff[v] <= req_tdata[(2*v+1)*C +: C];
         end
         weight_ff <= req_tdata[8*C +: WF];
      end
      if (load) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= ovf_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

`ifndef SYNTHESIS
   a_accept_to_check: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == S_CHECK))
      else $error("accepted item did not enter the check state");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_MERGES))
      else $error("member count exceeded the merge limit");
   a_match_in_state: assert property (@(posedge clock) disable iff (reset)
      match_done |-> (state_ff == S_MATCH))
      else $error("ordering search finished outside the match state");
`endif
endmodule

FILE: hdl/wqm_lane.sv
// One coordinate lane: weighted accumulator and iterative saturating divider.
`timescale 1ns / 1ps
module wqm_lane #(
   parameter int C     = 16,
   parameter int WF    = 16,
   parameter int WS    = 26,
   parameter int SUM_W = 42
) (
   input  logic                    clock,
   input  logic                    reset,
   input  wqm_pkg::lane_ctrl_type  ctrl,
   input  logic signed [C-1:0]     coord,
   input  logic [WF-1:0]           weight,
   input  logic [WS-1:0]           divisor,
   output logic signed [C-1:0]     avg,
   output logic                    done
);
   localparam int QB     = 2 * ((C + 2) / 2);
   localparam int STEPS  = QB / wqm_pkg::STEP_BITS;
   localparam int STEP_W = $clog2(STEPS + 1);
   localparam int CMP_W  = SUM_W + WS + QB;
   localparam logic [QB-1:0] POS_LIM = {{(QB-C+1){1'b0}}, {(C-1){1'b1}}};
   localparam logic [QB-1:0] NEG_LIM = {{(QB-C){1'b0}}, 1'b1, {(C-1){1'b0}}};
   localparam logic [C-1:0]  POS_MAX = {1'b0, {(C-1){1'b1}}};
   localparam logic [C-1:0]  NEG_MIN = {1'b1, {(C-1){1'b0}}};

   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic signed [C+WF:0]    prod_ff, prod_in;
   logic                    busy_ff, busy_in;
   logic [STEP_W-1:0]       step_ff, step_in;
   logic [WS-1:0]           rem_ff, rem_in;
   logic [QB-1:0]           shf_ff, shf_in;
   logic [QB-1:0]           quo_ff, quo_in;
   logic                    neg_ff, neg_in;
   logic                    sat_ff, sat_in;
   logic [WS-1:0]           dvs_ff, dvs_in;
   logic [C-1:0]            avg_ff, avg_in;
   logic                    done_ff, done_in;
   logic [SUM_W-1:0]        mag;
   logic [WS-1:0]           r;
   logic [QB-1:0]           s;
   logic [QB-1:0]           q;
   logic [WS:0]             t;

   assign prod_in = coord * $signed({1'b0, weight});

   always_comb begin
      sum_in = sum_ff;
      if (ctrl.clear) begin
         sum_in = '0;
      end else if (ctrl.add_en) begin
         sum_in = sum_ff + SUM_W'(prod_ff);
      end
   end

   always_comb begin
      mag = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
      r = rem_ff;
      s = shf_ff;
      q = quo_ff;
      for (int j = 0; j < wqm_pkg::STEP_BITS; j++) begin
         t = {r, s[QB-1]};
         s = {s[QB-2:0], 1'b0};
         if (t >= {1'b0, dvs_ff}) begin
            t = t - {1'b0, dvs_ff};
            q = {q[QB-2:0], 1'b1};
         end else begin
            q = {q[QB-2:0], 1'b0};
         end
         r = t[WS-1:0];
      end
      busy_in = busy_ff;
      step_in = step_ff;
      rem_in  = rem_ff;
      shf_in  = shf_ff;
      quo_in  = quo_ff;
      neg_in  = neg_ff;
      sat_in  = sat_ff;
      dvs_in  = dvs_ff;
      avg_in  = avg_ff;
      done_in = 1'b0;
      if (ctrl.div_start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(STEPS);
         rem_in  = WS'(mag >> QB);
         shf_in  = mag[QB-1:0];
         quo_in  = '0;
         neg_in  = sum_ff[SUM_W-1];
         sat_in  = CMP_W'(mag) >= (CMP_W'(divisor) << QB);
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (step_ff != '0) begin
            rem_in  = r;
            shf_in  = s;
            quo_in  = q;
            step_in = step_ff - STEP_W'(1);
         end else begin
            busy_in = 1'b0;
            done_in = 1'b1;
            if (neg_ff) begin
               avg_in = (sat_ff || quo_ff > NEG_LIM) ? NEG_MIN : C'(-quo_ff[C-1:0]);
            end else begin
               avg_in = (sat_ff || quo_ff > POS_LIM) ? POS_MAX : quo_ff[C-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         sum_ff  <= sum_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      prod_ff <= ctrl.mul_en ? prod_in : prod_ff;
      step_ff <= step_in;
      rem_ff  <= rem_in;
      shf_ff  <= shf_in;
      quo_ff  <= quo_in;
      neg_ff  <= neg_in;
      sat_ff  <= sat_in;
      dvs_ff  <= dvs_in;
      avg_ff  <= avg_in;
   end

   assign avg  = avg_ff;
   assign done = done_ff;
endmodule

FILE: hdl/wqm_match.sv
// Merging stage: squared distance costs of the eight vertex orderings and best pick.
`timescale 1ns / 1ps
module wqm_match #(
   parameter int C = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic signed [C-1:0] avg_x [wqm_pkg::NUM_VERTS],
   input  logic signed [C-1:0] avg_y [wqm_pkg::NUM_VERTS],
   input  logic signed [C-1:0] pt_x  [wqm_pkg::NUM_VERTS],
   input  logic signed [C-1:0] pt_y  [wqm_pkg::NUM_VERTS],
   output logic [1:0]          pick_start,
   output logic                best_rev,
   output logic                done
);
   localparam int SQ_W   = 2 * C + 2;
   localparam int PAIR_W = 2 * C + 3;
   localparam int COST_W = 2 * C + 5;
   localparam logic [2:0] MS_IDLE = 3'd0;
   localparam logic [2:0] MS_PAIR = 3'd1;
   localparam logic [2:0] MS_COST = 3'd2;
   localparam logic [2:0] MS_SCAN = 3'd3;

   logic [2:0]        state_ff, state_in;
   logic [SQ_W-1:0]   sqx_ff [4][4];
   logic [SQ_W-1:0]   sqy_ff [4][4];
   logic [PAIR_W-1:0] pair_ff [4][4];
   logic [COST_W-1:0] cost_ff [wqm_pkg::NUM_ORDERS];
   logic [COST_W-1:0] cost_in [wqm_pkg::NUM_ORDERS];
   logic [COST_W-1:0] best_ff;
   logic [2:0]        idx_ff;
   logic [2:0]        best_idx_ff;
   logic              done_ff;
   logic [1:0]        src;
   logic [1:0]        os;

   function automatic logic [SQ_W-1:0] sq_dist(input logic signed [C-1:0] a,
                                               input logic signed [C-1:0] b);
      logic signed [C:0] d;
      logic [C:0]        m;
      d = {a[C-1], a} - {b[C-1], b};
      m = d[C] ? -d : d;
      return SQ_W'(m) * SQ_W'(m);
   endfunction

   always_comb begin
      for (int o = 0; o < wqm_pkg::NUM_ORDERS; o++) begin
         os = 2'(o >> 1);
         cost_in[o] = '0;
         for (int i = 0; i < 4; i++) begin
            src = o[0] ? (os + 2'd3 - 2'(i)) : (os + 2'(i));
            cost_in[o] = cost_in[o] + COST_W'(pair_ff[i][src]);
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         MS_IDLE: if (start) state_in = MS_PAIR;
         MS_PAIR: state_in = MS_COST;
         MS_COST: state_in = MS_SCAN;
         MS_SCAN: if (idx_ff == 3'd7) state_in = MS_IDLE;
         default: state_in = MS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MS_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= (state_ff == MS_SCAN) && (idx_ff == 3'd7);
      end
      if (state_ff == MS_IDLE && start) begin
         for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
               sqx_ff[i][j] <= sq_dist(avg_x[i], pt_x[j]);
               sqy_ff[i][j] <= sq_dist(avg_y[i], pt_y[j]);
            end
         end
      end
      if (state_ff == MS_PAIR) begin
         for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
               pair_ff[i][j] <= PAIR_W'(sqx_ff[i][j]) + PAIR_W'(sqy_ff[i][j]);
            end
         end
      end
      if (state_ff == MS_COST) begin
         cost_ff <= cost_in;
         idx_ff  <= 3'd0;
      end
      if (state_ff == MS_SCAN) begin
         idx_ff <= idx_ff + 3'd1;
         if (idx_ff == 3'd0 || cost_ff[idx_ff] < best_ff) begin
            best_ff     <= cost_ff[idx_ff];
            best_idx_ff <= idx_ff;
         end
      end
   end

   assign pick_start = best_idx_ff[2:1];
   assign best_rev   = best_idx_ff[0];
   assign done       = done_ff;
endmodule

FILE: sim/tb_weighted_quad_merger.sv
// Self-checking testbench for the weighted quadrangle merger with random stream stalls.
`timescale 1ns / 1ps
module tb_weighted_quad_merger;
   localparam int MAX_GROUP = 1024;
   localparam int REQ_W = ((8*16+15+1+7)/8)*8;
   localparam int RSP_W = ((8*16+15+1+$clog2(MAX_GROUP)+7)/8)*8;

   typedef struct {
      logic start;
      logic signed [15:0] crd [8];
      logic [15:0] wgt;
   } quad_item_type;

   typedef struct {
      logic signed [15:0] avg [8];
      logic [25:0] total;
      logic ovf;
   } merge_out_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic rsp_tuser;

   quad_item_type pending_quads[$];
   merge_out_type expected_merges[$];
   longint signed acc_sum [8];
   longint unsigned acc_weight;
   int unsigned members;
   bit ovf_flag;
   int errors = 0;
   bit stim_done = 0;
   bit calm = 0;
   bit hold_long = 0;
   int send_gap = 0;
   int recv_gap = 0;
   int hold_cnt = 0;
   longint cycles = 0;

   weighted_quad_merger #(.MAX_MERGES(MAX_GROUP)) i_dut (.*);

   always #2 clock = ~clock;

   function automatic longint signed merge_avg(longint signed s);
      longint signed d, q;
      d = (acc_weight == 0) ? 1 : longint'(acc_weight);
      q = s / d;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return q;
   endfunction

   function automatic longint unsigned sqd(longint signed a, longint signed b);
      longint signed d;
      d = a - b;
      return longint'(d * d);
   endfunction

   task automatic merge_quad(input quad_item_type it);
      longint signed p [8], r [8], a [8];
      longint unsigned cost, best;
      int bs, br, src;
      merge_out_type res;
      if (it.start) begin
         foreach (acc_sum[k]) acc_sum[k] = 0;
         acc_weight = 0;
         members = 0;
         ovf_flag = 0;
      end
      foreach (p[k]) begin
         p[k] = longint'(it.crd[k]);
         r[k] = p[k];
      end
      if (members >= MAX_GROUP) begin
         ovf_flag = 1;
      end else begin
         if (members > 0) begin
            foreach (a[k]) a[k] = merge_avg(acc_sum[k]);
            best = 0;
            bs = 0;
            br = 0;
            for (int s = 0; s < 4; s++) begin
               for (int rv = 0; rv < 2; rv++) begin
                  cost = 0;
                  for (int i = 0; i < 4; i++) begin
                     src = rv ? ((s + 3 - i) & 3) : ((s + i) & 3);
                     cost += sqd(a[2*i], p[2*src]) + sqd(a[2*i+1], p[2*src+1]);
                  end
                  if ((s == 0 && rv == 0) || cost < best) begin
                     best = cost;
                     bs = s;
                     br = rv;
                  end
               end
            end
            for (int i = 0; i < 4; i++) begin
               src = br ? ((bs + 3 - i) & 3) : ((bs + i) & 3);
               r[2*i] = p[2*src];
               r[2*i+1] = p[2*src+1];
            end
         end
         foreach (acc_sum[k]) acc_sum[k] += r[k] * longint'(it.wgt);
         acc_weight = (acc_weight + it.wgt) & 64'h3FF_FFFF;
         members++;
      end
      foreach (res.avg[k]) res.avg[k] = 16'(merge_avg(acc_sum[k]));
      res.total = acc_weight[25:0];
      res.ovf = ovf_flag;
      expected_merges.push_back(res);
   endtask

   function automatic quad_item_type rand_quad(bit start, int spread);
      quad_item_type it;
      int cx, cy;
      it.start = start;
      cx = $urandom_range(65535) - 32768;
      cy = $urandom_range(65535) - 32768;
      foreach (it.crd[k]) begin
         if (spread == 0) it.crd[k] = 16'($urandom);
         else it.crd[k] = 16'(((k % 2) ? cy : cx) + int'($urandom_range(2*spread)) - spread);
      end
      case ($urandom_range(9))
         0: it.wgt = 0;
         1: it.wgt = 32768;
         default: it.wgt = 16'($urandom_range(32768));
      endcase
      return it;
   endfunction

   initial begin
      quad_item_type it;
      int glen;
      foreach (acc_sum[k]) acc_sum[k] = 0;
      acc_weight = 0;
      members = 0;
      ovf_flag = 0;
      // Directed: extremes, zero weights, full weights and rotated/reversed copies.
      it.start = 1;
      foreach (it.crd[k]) it.crd[k] = 16'sh8000;
      it.wgt = 0;
      pending_quads.push_back(it);
      it.start = 0;
      foreach (it.crd[k]) it.crd[k] = 16'sh7FFF;
      it.wgt = 32768;
      pending_quads.push_back(it);
      foreach (it.crd[k]) it.crd[k] = (k % 2) ? 16'sh8000 : 16'sh7FFF;
      it.wgt = 16'hFFFF;
      pending_quads.push_back(it);
      it.start = 1;
      it.crd = '{0, 0, 100, 0, 100, 100, 0, 100};
      it.wgt = 32768;
      pending_quads.push_back(it);
      it.start = 0;
      it.crd = '{100, 100, 0, 100, 0, 0, 100, 0};
      pending_quads.push_back(it);
      it.crd = '{0, 100, 100, 100, 100, 0, 0, 0};
      pending_quads.push_back(it);
      it.crd = '{0, 0, 0, 0, 0, 0, 0, 0};
      it.wgt = 0;
      pending_quads.push_back(it);
      for (int i = 0; i < 8; i++) pending_quads.push_back(rand_quad(i == 0, 0));
      // One group runs past the merge limit.
      for (int i = 0; i < MAX_GROUP + 3; i++) pending_quads.push_back(rand_quad(i == 0, 50));
      while (pending_quads.size() < 1100) begin
         glen = $urandom_range(1, 12);
         for (int i = 0; i < glen; i++)
            pending_quads.push_back(rand_quad(i == 0 || $urandom_range(15) == 0,
                                              $urandom_range(3) == 0 ? 0 : 200));
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   // Driver
   always @(posedge clock) begin
      quad_item_type it;
      logic [REQ_W-1:0] pk;
      if (!reset) begin
         if (req_tvalid && req_tready) merge_quad(pending_quads.pop_front());
         if (pending_quads.size() < 50) calm <= 1'b1;
         if (!(req_tvalid && !req_tready)) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_tvalid <= 1'b0;
            end else if (!calm && $urandom_range(7) == 0) begin
               send_gap <= $urandom_range(1, 17) - 1;
               req_tvalid <= 1'b0;
            end else if (pending_quads.size() > 0) begin
               it = pending_quads[0];
               pk = '0;
               for (int k = 0; k < 8; k++) pk[16*k +: 16] = it.crd[k];
               pk[128 +: 16] = it.wgt;
               req_tvalid <= 1'b1;
               req_tuser <= it.start;
               req_tdata <= pk;
            end else begin
               req_tvalid <= 1'b0;
               stim_done <= 1'b1;
            end
         end
      end
   end

   // Monitor and receiver
   always @(posedge clock) begin
      merge_out_type e;
      int bad;
      bad = 0;
      if (!reset) begin
         cycles <= cycles + 1;
         if (rsp_tvalid && rsp_tready) begin
            if (expected_merges.size() == 0) begin
               $display("%0t: unexpected result %h", $time, rsp_tdata);
               bad = bad + 1;
            end else begin
               e = expected_merges.pop_front();
               for (int k = 0; k < 8; k++)
                  if (rsp_tdata[16*k +: 16] !== e.avg[k]) begin
                     $display("%0t: avg[%0d] expected %0d actual %0d", $time, k, e.avg[k],
                              $signed(rsp_tdata[16*k +: 16]));
                     bad = bad + 1;
                  end
               if (rsp_tdata[128 +: 26] !== e.total) begin
                  $display("%0t: total expected %0d actual %0d", $time, e.total,
                           rsp_tdata[128 +: 26]);
                  bad = bad + 1;
               end
               if (rsp_tuser !== e.ovf) begin
                  $display("%0t: overflow expected %0b actual %0b", $time, e.ovf, rsp_tuser);
                  bad = bad + 1;
               end
            end
         end
         errors <= errors + bad;
         if (cycles == 3000 && !hold_long) begin
            hold_long <= 1'b1;
            hold_cnt <= 400;
            rsp_tready <= 1'b0;
         end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            rsp_tready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            rsp_tready <= 1'b0;
         end else if (!calm && $urandom_range(6) == 0) begin
            recv_gap <= $urandom_range(1, 17) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      wait (!reset);
      fork
         begin
            wait (stim_done && expected_merges.size() == 0);
            repeat (100) @(posedge clock);
            if (errors == 0) $display("PASS weighted_quad_merger");
            else $display("FAIL weighted_quad_merger");
         end
         begin
            wait (cycles == 1000000);
            $display("FAIL weighted_quad_merger");
         end
      join_any
      $finish;
   end
endmodule
